>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk; RSQ_ASSERT is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk once reset is released
`define RSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included
`define RSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Types, constants and the arctangent table for the rotated sprite setup.
// ----------------------------------------------------------------------------
package rsq_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int NUM_STEPS       = 16;

  // register indexes
  localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COLOR      = 2'd2;

  // corner codes
  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  localparam logic [15:0] UV_ONE     = 16'd32768;
  localparam logic signed [17:0] CORDIC_X0 = 18'sd19898;

  typedef struct packed {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [14:0]        dest_width;
    logic [14:0]        dest_height;
    logic [15:0]        source_x;
    logic [15:0]        source_y;
    logic [15:0]        source_width;
    logic [15:0]        source_height;
    logic [15:0]        rotation_angle;
    logic signed [15:0] pivot_offset_x;
    logic signed [15:0] pivot_offset_y;
    logic [3:0]         mode_bits;
  } sprite_req_t;

  typedef struct packed {
    logic [1:0]         corner_index;
    logic signed [15:0] position_x;
    logic signed [15:0] position_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic               last_corner;
  } vertex_t;

  // one corner slot travelling down the cell row
  typedef struct packed {
    logic [1:0]         corner;
    logic signed [18:0] ox;
    logic signed [18:0] oy;
    logic signed [19:0] pax;
    logic signed [19:0] pay;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [17:0] cz;
    logic               neg;
    logic [28:0]        rem_u;
    logic [28:0]        rem_v;
    logic [12:0]        du;
    logic [12:0]        dv;
    logic [15:0]        qu;
    logic [15:0]        qv;
    logic               ovf_u;
    logic               ovf_v;
  } slot_t;

  // arctangent of 2^-i in 16-bit binary angle units
  function automatic logic [13:0] atan_unit(input int i);
    logic [13:0] r;
    case (i)
      0:       r = 14'd8192;
      1:       r = 14'd4836;
      2:       r = 14'd2555;
      3:       r = 14'd1297;
      4:       r = 14'd651;
      5:       r = 14'd326;
      6:       r = 14'd163;
      7:       r = 14'd81;
      8:       r = 14'd41;
      9:       r = 14'd20;
      10:      r = 14'd10;
      11:      r = 14'd5;
      12:      r = 14'd3;
      13:      r = 14'd1;
      14:      r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/rotated_sprite_quad_setup_core.sv
// ----------------------------------------------------------------------------
// rotated_sprite_quad_setup_core
// Sprite request in, four rotated textured vertices out.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and gives four
// vertices (top-left, top-right, bottom-right, bottom-left) on consecutive
// cycles, each marked by out_valid for one cycle; the receiver cannot stall.
// A new request can be taken while the last corner of the previous one is
// issued: the corner sequencer issues one corner a cycle into a row of 16
// CORDIC/divider cells, then a two-stage multiply and round unit.
// Configuration writes take effect at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotated_sprite_quad_setup_core
  import rsq_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  sprite_req_t in_req,
  output logic        out_valid,
  output vertex_t     out_vtx,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int SH_R = (ANGLE_WIDTH >= 16) ? ANGLE_WIDTH - 16 : 0;
  localparam int SH_L = (ANGLE_WIDTH < 16) ? 16 - ANGLE_WIDTH : 0;
  localparam logic [39:0] ANG_MASK = (40'd1 << ANGLE_WIDTH) - 40'd1;

  logic [12:0]  tex_w_r;
  logic [12:0]  tex_h_r;
  logic [31:0]  color_r;
  sprite_req_t  item_r;
  logic         active_r;
  logic [1:0]   k_r;
  logic         accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= 13'd1;
      tex_h_r <= 13'd1;
      color_r <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:  tex_w_r <= cfg_wdata[12:0];
        REG_TEX_HEIGHT: tex_h_r <= cfg_wdata[12:0];
        REG_COLOR:      color_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // corner sequencer: one corner a cycle, next request on the last corner
  assign busy   = active_r && (k_r != CORNER_BL);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      k_r      <= CORNER_TL;
    end else if (accept) begin
      active_r <= 1'b1;
      k_r      <= CORNER_TL;
    end else if (active_r) begin
      if (k_r == CORNER_BL) active_r <= 1'b0;
      else                  k_r <= k_r + 2'd1;
    end
    if (accept) item_r <= in_req;
  end

  // corner setup feeding the first cell
  logic               right;
  logic               bottom;
  logic signed [19:0] w_s, h_s, prx, pry, ox20, oy20;
  logic [16:0]        sx, sy, sw, sh, u_hi, v_hi, cu, cv;
  logic [12:0]        du, dv;
  logic [39:0]        ang_ext;
  logic [15:0]        a16;
  logic signed [17:0] z;
  logic               neg;
  slot_t              slot0;

  always_comb begin
    right  = k_r[0] ^ k_r[1];
    bottom = k_r[1];
    w_s    = {5'b0, item_r.dest_width};
    h_s    = {5'b0, item_r.dest_height};
    prx    = item_r.mode_bits[0] ?
             {{3{item_r.pivot_offset_x[15]}}, item_r.pivot_offset_x, 1'b0} : w_s;
    pry    = item_r.mode_bits[0] ?
             {{3{item_r.pivot_offset_y[15]}}, item_r.pivot_offset_y, 1'b0} : h_s;
    ox20   = (right ? (w_s <<< 1) : 20'sd0) - prx;
    oy20   = (bottom ? (h_s <<< 1) : 20'sd0) - pry;

    // texture rectangle and mirroring
    sx = item_r.mode_bits[1] ? {1'b0, item_r.source_x} : 17'd0;
    sy = item_r.mode_bits[1] ? {1'b0, item_r.source_y} : 17'd0;
    sw = item_r.mode_bits[1] ? {1'b0, item_r.source_width} : {tex_w_r, 4'b0};
    sh = item_r.mode_bits[1] ? {1'b0, item_r.source_height} : {tex_h_r, 4'b0};
    u_hi = sx + sw;
    v_hi = sy + sh;
    cu = (right ^ item_r.mode_bits[2]) ? u_hi : sx;
    cv = (bottom ^ item_r.mode_bits[3]) ? v_hi : sy;
    du = (tex_w_r == 13'd0) ? 13'd1 : tex_w_r;
    dv = (tex_h_r == 13'd0) ? 13'd1 : tex_h_r;

    // angle to 16-bit units, folded to a quarter turn either side
    ang_ext = {24'b0, item_r.rotation_angle} & ANG_MASK;
    a16     = 16'((ang_ext >> SH_R) << SH_L);
    z       = {{2{a16[15]}}, a16};
    neg     = 1'b0;
    if (z > 18'sd16384) begin
      z   = z - 18'sd32768;
      neg = 1'b1;
    end else if (z < -18'sd16384) begin
      z   = z + 18'sd32768;
      neg = 1'b1;
    end

    slot0.corner = k_r;
    slot0.ox     = ox20[18:0];
    slot0.oy     = oy20[18:0];
    slot0.pax    = {{3{item_r.dest_x[15]}}, item_r.dest_x, 1'b0} + prx;
    slot0.pay    = {{3{item_r.dest_y[15]}}, item_r.dest_y, 1'b0} + pry;
    slot0.cx     = CORDIC_X0;
    slot0.cy     = 18'sd0;
    slot0.cz     = z;
    slot0.neg    = neg;
    slot0.rem_u  = {1'b0, cu, 11'b0} + {17'b0, du[12:1]};
    slot0.rem_v  = {1'b0, cv, 11'b0} + {17'b0, dv[12:1]};
    slot0.du     = du;
    slot0.dv     = dv;
    slot0.qu     = 16'd0;
    slot0.qv     = 16'd0;
    slot0.ovf_u  = slot0.rem_u >= ({1'b0, du, 15'b0} + {16'b0, du});
    slot0.ovf_v  = slot0.rem_v >= ({1'b0, dv, 15'b0} + {16'b0, dv});
  end

  // row of cells
  logic  valid_c [NUM_STEPS+1];
  slot_t slot_c  [NUM_STEPS+1];

  assign valid_c[0] = active_r;
  assign slot_c[0]  = slot0;

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_cell
    rsq_cell #(.STEP(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (valid_c[g]),
      .slot_in   (slot_c[g]),
      .valid_out (valid_c[g+1]),
      .slot_out  (slot_c[g+1])
    );
  end

  rsq_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (valid_c[NUM_STEPS]),
    .slot_in   (slot_c[NUM_STEPS]),
    .color     (color_r),
    .out_valid (out_valid),
    .out_vtx   (out_vtx)
  );

  // checks
  `RSQ_ASSERT(a_last_flag, out_valid |-> (out_vtx.last_corner == (out_vtx.corner_index == CORNER_BL)), "last_corner does not match corner index")
  `RSQ_ASSERT(a_corner_seq, (out_valid && out_vtx.corner_index != CORNER_BL) |=> (out_valid && out_vtx.corner_index == $past(out_vtx.corner_index) + 2'd1), "vertices of a quad not consecutive")
  `RSQ_ASSERT(a_uv_range, out_valid |-> (out_vtx.tex_u <= UV_ONE && out_vtx.tex_v <= UV_ONE), "texture coordinate above one")
  `RSQ_ASSERT(a_busy_after_accept, accept |=> busy, "request taken but sequencer not busy")

endmodule

>>> rtl/core/rsq_cell.sv
// ----------------------------------------------------------------------------
// rsq_cell
// One cell of the row: a CORDIC micro-rotation and one quotient bit for u, v.
// ----------------------------------------------------------------------------
module rsq_cell
  import rsq_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_in,
  input  slot_t slot_in,
  output logic  valid_out,
  output slot_t slot_out
);

  localparam int QBIT = NUM_STEPS - 1 - STEP;

  logic          valid_r;
  slot_t         slot_r;
  slot_t         slot_nxt;
  logic signed [17:0] xs;
  logic signed [17:0] ys;
  logic [28:0]   sub_u;
  logic [28:0]   sub_v;
  logic signed [17:0] atan_s;

  // micro-rotation and restoring divide step
  always_comb begin
    slot_nxt = slot_in;
    xs       = slot_in.cx >>> STEP;
    ys       = slot_in.cy >>> STEP;
    atan_s   = signed'({4'b0, atan_unit(STEP)});
    if (!slot_in.cz[17]) begin
      slot_nxt.cx = slot_in.cx - ys;
      slot_nxt.cy = slot_in.cy + xs;
      slot_nxt.cz = slot_in.cz - atan_s;
    end else begin
      slot_nxt.cx = slot_in.cx + ys;
      slot_nxt.cy = slot_in.cy - xs;
      slot_nxt.cz = slot_in.cz + atan_s;
    end
    sub_u = {16'b0, slot_in.du} << QBIT;
    sub_v = {16'b0, slot_in.dv} << QBIT;
    if (slot_in.rem_u >= sub_u) begin
      slot_nxt.rem_u    = slot_in.rem_u - sub_u;
      slot_nxt.qu[QBIT] = 1'b1;
    end
    if (slot_in.rem_v >= sub_v) begin
      slot_nxt.rem_v    = slot_in.rem_v - sub_v;
      slot_nxt.qv[QBIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    slot_r <= slot_nxt;
  end

  assign valid_out = valid_r;
  assign slot_out  = slot_r;

endmodule

>>> rtl/core/rsq_rotate.sv
// ----------------------------------------------------------------------------
// rsq_rotate
// Rotates the corner offset by sine/cosine, rounds, saturates, forms vertex.
// ----------------------------------------------------------------------------
module rsq_rotate
  import rsq_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_in,
  input  slot_t       slot_in,
  input  logic [31:0] color,
  output logic        out_valid,
  output vertex_t     out_vtx
);

  localparam int SAT_W = (COORD_WIDTH > 16) ? 16 : COORD_WIDTH;
  localparam logic signed [39:0] POS_HI = (40'sd1 <<< (SAT_W - 1)) - 40'sd1;
  localparam logic signed [39:0] POS_LO = -POS_HI - 40'sd1;
  localparam logic signed [39:0] HALF   = 40'sd32768;

  logic signed [18:0] cs;
  logic signed [18:0] sn;
  logic               valid_r;
  logic [1:0]         corner_r;
  logic signed [19:0] pax_r;
  logic signed [19:0] pay_r;
  logic signed [36:0] pxc_r;
  logic signed [36:0] pys_r;
  logic signed [36:0] pxs_r;
  logic signed [36:0] pyc_r;
  logic [15:0]        u_r;
  logic [15:0]        v_r;
  logic signed [39:0] sum_x;
  logic signed [39:0] sum_y;
  logic signed [39:0] sh_x;
  logic signed [39:0] sh_y;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  vertex_t            vtx_nxt;
  logic               out_valid_r;
  vertex_t            out_vtx_r;

  // undo the quadrant fold
  always_comb begin
    cs = slot_in.neg ? -{slot_in.cx[17], slot_in.cx} : {slot_in.cx[17], slot_in.cx};
    sn = slot_in.neg ? -{slot_in.cy[17], slot_in.cy} : {slot_in.cy[17], slot_in.cy};
  end

  // products stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    corner_r <= slot_in.corner;
    pax_r    <= slot_in.pax;
    pay_r    <= slot_in.pay;
    pxc_r    <= 37'(slot_in.ox * cs);
    pys_r    <= 37'(slot_in.oy * sn);
    pxs_r    <= 37'(slot_in.ox * sn);
    pyc_r    <= 37'(slot_in.oy * cs);
    u_r      <= slot_in.ovf_u ? UV_ONE : slot_in.qu;
    v_r      <= slot_in.ovf_v ? UV_ONE : slot_in.qv;
  end

  // sum, round half up, saturate
  always_comb begin
    sum_x = (40'(pax_r) <<< 15) + 40'(pxc_r) - 40'(pys_r) + HALF;
    sum_y = (40'(pay_r) <<< 15) + 40'(pxs_r) + 40'(pyc_r) + HALF;
    sh_x  = sum_x >>> 16;
    sh_y  = sum_y >>> 16;
    if (sh_x > POS_HI)      pos_x = POS_HI[15:0];
    else if (sh_x < POS_LO) pos_x = POS_LO[15:0];
    else                    pos_x = sh_x[15:0];
    if (sh_y > POS_HI)      pos_y = POS_HI[15:0];
    else if (sh_y < POS_LO) pos_y = POS_LO[15:0];
    else                    pos_y = sh_y[15:0];
    vtx_nxt.corner_index = corner_r;
    vtx_nxt.position_x   = pos_x;
    vtx_nxt.position_y   = pos_y;
    vtx_nxt.tex_u        = u_r;
    vtx_nxt.tex_v        = v_r;
    vtx_nxt.vertex_color = color;
    vtx_nxt.last_corner  = (corner_r == CORNER_BL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid_r;
    end
    out_vtx_r <= vtx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_vtx   = out_vtx_r;

endmodule
